### sv/psr_pkg.sv
// Shared types and constants for the PSI section reassembler.
package psr_pkg;

   localparam logic [2:0] KIND_BYTE     = 3'd0;
   localparam logic [2:0] KIND_GOOD     = 3'd1;
   localparam logic [2:0] KIND_CRC_ERR  = 3'd2;
   localparam logic [2:0] KIND_REJECTED = 3'd3;
   localparam logic [2:0] KIND_ABANDON  = 3'd4;

   localparam logic [1:0] CSR_EXTENDED_HEADER = 2'd0;
   localparam logic [1:0] CSR_IGNORE_ORDER    = 2'd1;

   typedef enum logic [1:0] {
      PHASE_IDLE,
      PHASE_CONT,
      PHASE_NEW
   } psr_phase_type;

   localparam logic [7:0]  FILLER_BYTE    = 8'hFF;
   localparam logic [7:0]  RESERVED_MASK  = 8'h30;
   localparam logic [7:0]  VERSION_MASK   = 8'hC0;
   localparam logic [11:0] MIN_LONG_LEN   = 12'd9;
   localparam logic [12:0] HDR_SHORT      = 13'd3;
   localparam logic [12:0] HDR_LONG       = 13'd8;
   localparam logic [31:0] CRC_POLY       = 32'h04C11DB7;
   localparam logic [31:0] CRC_INIT       = 32'hFFFFFFFF;
   localparam logic [31:0] COUNT_MAX      = 32'hFFFFFFFF;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  section_byte;
      logic [11:0] byte_offset;
      logic [7:0]  tbl_id;
      logic [11:0] sect_len;
      logic [31:0] crc_error_count;
      logic        last;
   } psr_result_type;

   typedef struct packed {
      logic                      load;
      logic [1:0]                count;
      psr_result_type [1:0]      res;
   } psr_batch_type;

endpackage

### sv/psr_if.sv
// Request, response and register-write channel interfaces.
interface psr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_of_packet;
   logic       unit_start;
   logic [7:0] payload_length;
   modport source (output valid, data_byte, first_of_packet, unit_start, payload_length,
                   input ready);
   modport sink   (input valid, data_byte, first_of_packet, unit_start, payload_length,
                   output ready);
endinterface

interface psr_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  section_byte;
   logic [11:0] byte_offset;
   logic [7:0]  tbl_id;
   logic [11:0] sect_len;
   logic [31:0] crc_error_count;
   logic        last;
   modport source (output valid, kind, section_byte, byte_offset, tbl_id, sect_len,
                   crc_error_count, last, input ready);
   modport sink   (input valid, kind, section_byte, byte_offset, tbl_id, sect_len,
                   crc_error_count, last, output ready);
endinterface

interface psr_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic       data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### sv/psr_core.sv
// Input register, section state and per-byte reassembly logic.
module psr_core #(
   parameter int MAX_SECTION_LENGTH = 4093
) (
   input  logic                   clock,
   input  logic                   reset,
   psr_req_if.sink                req,
   psr_csr_if.sink                csr,
   input  logic                   can_load,
   output psr_pkg::psr_batch_type batch
);
   import psr_pkg::*;

   localparam logic [11:0] MAX_LEN = 12'(MAX_SECTION_LENGTH);

   logic            in_vld_ff;
   logic [7:0]      in_byte_ff;
   logic            in_fop_ff;
   logic            in_us_ff;
   logic [7:0]      in_len_ff;

   logic            ext_ff;
   logic            ign_ff;

   psr_phase_type   phase_ff, phase_in;
   logic [7:0]      pos_ff, pos_in;
   logic [8:0]      usp_ff, usp_in;
   logic [7:0]      plen_ff, plen_in;
   logic            punit_ff, punit_in;
   logic [7:0][7:0] hdr_ff, hdr_in;
   logic [12:0]     cnt_ff, cnt_in;
   logic [12:0]     target_ff, target_in;
   logic            storing_ff, storing_in;
   logic [31:0]     crc_ff, crc_in;
   logic [31:0]     errs_ff, errs_in;

   logic            advance;
   psr_result_type [1:0] res;
   logic [1:0]      nres;
   logic            done;
   logic            in_prog;
   logic            do_feed;
   logic            close;
   logic [12:0]     hsize;

   function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {b, 24'd0};
      for (int i = 0; i < 8; i++) begin
         r = r[31] ? ((r << 1) ^ CRC_POLY) : (r << 1);
      end
      return r;
   endfunction

   function automatic logic [11:0] slen_of(input logic [7:0][7:0] h);
      return {h[1][3:0], h[2]};
   endfunction

   function automatic logic hdr_ok(input logic [7:0][7:0] h, input logic ext,
                                   input logic ign);
      logic ok;
      logic [11:0] sl;
      sl = slen_of(h);
      ok = 1'b1;
      if (h[0] == FILLER_BYTE) ok = 1'b0;
      if ((h[1] & RESERVED_MASK) != RESERVED_MASK) ok = 1'b0;
      if (sl > MAX_LEN) ok = 1'b0;
      if (h[1][7] != ext) ok = 1'b0;
      if (h[1][7]) begin
         if ((h[5] & VERSION_MASK) != VERSION_MASK) ok = 1'b0;
         if (!ign && (h[6] > h[7])) ok = 1'b0;
         if (sl < MIN_LONG_LEN) ok = 1'b0;
      end
      return ok;
   endfunction

   function automatic psr_result_type mk(input logic [2:0] k, input logic [7:0] b,
                                         input logic [12:0] off,
                                         input logic [7:0][7:0] h,
                                         input logic [31:0] errs);
      psr_result_type r;
      r.kind            = k;
      r.section_byte    = (k == KIND_BYTE) ? b : 8'd0;
      r.byte_offset     = (k == KIND_BYTE) ? off[11:0] : 12'd0;
      r.tbl_id          = (k == KIND_BYTE) ? 8'd0 : h[0];
      r.sect_len        = (k == KIND_BYTE) ? 12'd0 : slen_of(h);
      r.crc_error_count = errs;
      r.last            = 1'b0;
      return r;
   endfunction

   assign advance   = in_vld_ff && can_load;
   assign req.ready = !in_vld_ff || advance;
   assign csr.ready = 1'b1;

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      usp_in     = usp_ff;
      plen_in    = plen_ff;
      punit_in   = punit_ff;
      hdr_in     = hdr_ff;
      cnt_in     = cnt_ff;
      target_in  = target_ff;
      storing_in = storing_ff;
      crc_in     = crc_ff;
      errs_in    = errs_ff;
      res        = '0;
      nres       = 2'd0;
      done       = 1'b0;
      in_prog    = 1'b0;
      do_feed    = 1'b0;
      close      = 1'b0;
      hsize      = ext_ff ? HDR_LONG : HDR_SHORT;

      if (in_fop_ff) begin
         plen_in  = in_len_ff;
         punit_in = in_us_ff;
         pos_in   = 8'd0;
         phase_in = PHASE_CONT;
         if (in_len_ff == 8'd0) begin
            phase_in = PHASE_IDLE;
            done     = 1'b1;
         end else if (in_us_ff) begin
            usp_in = {1'b0, in_byte_ff} + 9'd1;
            pos_in = 8'd1;
            if (usp_in >= {1'b0, in_len_ff}) phase_in = PHASE_IDLE;
            done = 1'b1;
         end
      end

      if (!done && (phase_in == PHASE_IDLE || pos_in >= plen_in)) begin
         phase_in = PHASE_IDLE;
         done     = 1'b1;
      end

      if (!done) begin
         if (phase_in == PHASE_CONT && punit_in && {1'b0, pos_in} == usp_in) begin
            if (cnt_in != 13'd0 || storing_in) begin
               res[nres[0]] = mk(KIND_ABANDON, 8'd0, 13'd0, hdr_in, errs_in);
               nres = nres + 2'd1;
               hdr_in     = '0;
               cnt_in     = 13'd0;
               target_in  = 13'd0;
               storing_in = 1'b0;
               crc_in     = CRC_INIT;
            end
            phase_in = PHASE_NEW;
         end

         in_prog = storing_in || (cnt_in != 13'd0);
         if (phase_in == PHASE_CONT) begin
            do_feed = in_prog;
         end else if (!in_prog && {1'b0, pos_in} != usp_in && in_byte_ff == FILLER_BYTE) begin
            phase_in = PHASE_IDLE;
         end else begin
            do_feed = 1'b1;
         end

         if (do_feed) begin
            res[nres[0]] = mk(KIND_BYTE, in_byte_ff, cnt_in, hdr_in, errs_in);
            nres = nres + 2'd1;
            crc_in = crc_step(crc_in, in_byte_ff);
            if (!storing_in) begin
               hdr_in[cnt_in[2:0]] = in_byte_ff;
               cnt_in = cnt_in + 13'd1;
               if (cnt_in >= hsize) begin
                  if (!hdr_ok(hdr_in, ext_ff, ign_ff)) begin
                     res[nres[0]] = mk(KIND_REJECTED, 8'd0, 13'd0, hdr_in, errs_in);
                     nres = nres + 2'd1;
                     hdr_in     = '0;
                     cnt_in     = 13'd0;
                     target_in  = 13'd0;
                     storing_in = 1'b0;
                     crc_in     = CRC_INIT;
                     if (phase_in == PHASE_NEW) phase_in = PHASE_IDLE;
                  end else begin
                     target_in  = HDR_SHORT + {1'b0, slen_of(hdr_in)};
                     storing_in = 1'b1;
                     close      = cnt_in >= target_in;
                  end
               end
            end else begin
               cnt_in = cnt_in + 13'd1;
               close  = cnt_in >= target_in;
            end
            if (close) begin
               if (crc_in == 32'd0) begin
                  res[nres[0]] = mk(KIND_GOOD, 8'd0, 13'd0, hdr_in, errs_in);
               end else begin
                  if (errs_in != COUNT_MAX) errs_in = errs_in + 32'd1;
                  res[nres[0]] = mk(KIND_CRC_ERR, 8'd0, 13'd0, hdr_in, errs_in);
               end
               nres = nres + 2'd1;
               hdr_in     = '0;
               cnt_in     = 13'd0;
               target_in  = 13'd0;
               storing_in = 1'b0;
               crc_in     = CRC_INIT;
            end
         end

         pos_in = pos_in + 8'd1;
         if (pos_in >= plen_in) phase_in = PHASE_IDLE;
      end

      if (nres != 2'd0) res[nres[1]].last = 1'b1;

      if (!advance) begin
         phase_in   = phase_ff;
         pos_in     = pos_ff;
         usp_in     = usp_ff;
         plen_in    = plen_ff;
         punit_in   = punit_ff;
         hdr_in     = hdr_ff;
         cnt_in     = cnt_ff;
         target_in  = target_ff;
         storing_in = storing_ff;
         crc_in     = crc_ff;
         errs_in    = errs_ff;
      end
   end

   assign batch.load  = advance;
   assign batch.count = nres;
   assign batch.res   = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         ext_ff     <= 1'b1;
         ign_ff     <= 1'b0;
         phase_ff   <= PHASE_IDLE;
         pos_ff     <= 8'd0;
         usp_ff     <= 9'd0;
         plen_ff    <= 8'd0;
         punit_ff   <= 1'b0;
         hdr_ff     <= '0;
         cnt_ff     <= 13'd0;
         target_ff  <= 13'd0;
         storing_ff <= 1'b0;
         crc_ff     <= CRC_INIT;
         errs_ff    <= 32'd0;
      end else begin
         if (req.valid && req.ready) begin
            in_vld_ff <= 1'b1;
         end else if (advance) begin
            in_vld_ff <= 1'b0;
         end
         if (csr.valid && csr.ready) begin
            if (csr.index == CSR_EXTENDED_HEADER) ext_ff <= csr.data;
            if (csr.index == CSR_IGNORE_ORDER) ign_ff <= csr.data;
         end
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         usp_ff     <= usp_in;
         plen_ff    <= plen_in;
         punit_ff   <= punit_in;
         hdr_ff     <= hdr_in;
         cnt_ff     <= cnt_in;
         target_ff  <= target_in;
         storing_ff <= storing_in;
         crc_ff     <= crc_in;
         errs_ff    <= errs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff <= req.data_byte;
         in_fop_ff  <= req.first_of_packet;
         in_us_ff   <= req.unit_start;
         in_len_ff  <= req.payload_length;
      end
   end

endmodule

### sv/psr_out_stage.sv
// Two-entry result register that drains one response per cycle while rsp.ready is high.
module psr_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  psr_pkg::psr_batch_type batch,
   output logic                   can_load,
   psr_rsp_if.source              rsp
);
   import psr_pkg::*;

   psr_result_type slot0_ff, slot0_in;
   psr_result_type slot1_ff, slot1_in;
   logic [1:0]     cnt_ff, cnt_in;
   logic           pop;

   assign pop      = (cnt_ff != 2'd0) && rsp.ready;
   assign can_load = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp.ready);

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      cnt_in   = cnt_ff;
      if (batch.load) begin
         slot0_in = batch.res[0];
         slot1_in = batch.res[1];
         cnt_in   = batch.count;
      end else if (pop) begin
         slot0_in = slot1_ff;
         cnt_in   = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp.valid           = cnt_ff != 2'd0;
   assign rsp.kind            = slot0_ff.kind;
   assign rsp.section_byte    = slot0_ff.section_byte;
   assign rsp.byte_offset     = slot0_ff.byte_offset;
   assign rsp.tbl_id          = slot0_ff.tbl_id;
   assign rsp.sect_len        = slot0_ff.sect_len;
   assign rsp.crc_error_count = slot0_ff.crc_error_count;
   assign rsp.last            = slot0_ff.last;

endmodule

### sv/psi_section_reassembler.sv
// PSI section reassembler top level.
// A request passes the input register, then the result register, before its first
// response is valid; it waits in the input register while the results cannot load.
// Throughput: one request per cycle while the result register can load; a byte
// that yields two responses holds up the input until both leave by the single port.
// Reset (synchronous): clears packet and section state, CRC error count,
// and sets extended_header to 1 and ignore_section_order to 0.
module psi_section_reassembler #(
   parameter int MAX_SECTION_LENGTH = 4093
) (
   input  logic      clock,
   input  logic      reset,
   psr_req_if.sink   req,
   psr_rsp_if.source rsp,
   psr_csr_if.sink   csr
);
   import psr_pkg::*;

   psr_batch_type batch;
   logic          can_load;

   psr_core #(
      .MAX_SECTION_LENGTH(MAX_SECTION_LENGTH)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .csr      (csr),
      .can_load (can_load),
      .batch    (batch)
   );

   psr_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .batch    (batch),
      .can_load (can_load),
      .rsp      (rsp)
   );

endmodule

### bench/psi_section_reassembler_tb.sv
// Self-checking bench: packetized PSI sections through the reassembler, checked per response.
`timescale 1ns / 1ps
module psi_section_reassembler_tb;
   import psr_pkg::*;

   localparam int unsigned MAX_LENGTH_FIELD     = 4093;
   localparam int unsigned CYCLE_LIMIT          = 300000;
   localparam int unsigned PHASE_REQUESTS       = 165;
   localparam int unsigned SETTLE_CYCLES        = 8;

   typedef enum int {
      FLAW_NONE, FLAW_FILLER_ID, FLAW_RESERVED, FLAW_SYNTAX,
      FLAW_VERSION, FLAW_ORDER, FLAW_SHORT_LEN, FLAW_CRC
   } section_flaw_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int unsigned cycle_count = 0;
   int unsigned sent_items = 0;
   int unsigned src_idle_pct = 31;
   int unsigned snk_idle_pct = 73;

   logic [7:0] carry_q [$];
   logic [7:0] section_q [$];
   logic       section_cut;
   logic       restart_next = 1'b0;

   psr_req_if req_ch ();
   psr_rsp_if rsp_ch ();
   psr_csr_if csr_ch ();

   psi_section_reassembler i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   function automatic logic [31:0] crc_after_byte(logic [31:0] crc_in, logic [7:0] b);
      logic [31:0] c;
      c = crc_in ^ {b, 24'h0};
      for (int i = 0; i < 8; i++) begin
         c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   class psi_section_tracker_type;
      logic        ext_hdr;
      logic        skip_order;
      psr_phase_type pkt_phase;
      int unsigned pos;
      int unsigned pointed_pos;
      int unsigned pkt_len;
      logic        pkt_unit;
      logic [7:0]  hdr [8];
      int unsigned section_fill;
      int unsigned section_end;
      logic        in_body;
      logic [31:0] run_crc;
      logic [31:0] crc_fail_total;
      psr_result_type step_buf [4];
      int unsigned step_n;
      psr_result_type expected_section_events [$];
      int unsigned requests;
      int unsigned checked;
      int unsigned mismatches;
      int unsigned kind_count [5];

      function new();
         ext_hdr = 1'b1;
         skip_order = 1'b0;
         pkt_phase = PHASE_IDLE;
         pos = 0;
         pointed_pos = 0;
         pkt_len = 0;
         pkt_unit = 1'b0;
         crc_fail_total = '0;
         requests = 0;
         checked = 0;
         mismatches = 0;
         foreach (kind_count[i]) kind_count[i] = 0;
         drop_section();
      endfunction

      function void drop_section();
         foreach (hdr[i]) hdr[i] = '0;
         section_fill = 0;
         section_end = 0;
         in_body = 1'b0;
         run_crc = CRC_INIT;
      endfunction

      function logic [11:0] hdr_length();
         return {hdr[1][3:0], hdr[2]};
      endfunction

      function void write_register(logic [1:0] idx, logic val);
         case (idx)
            CSR_EXTENDED_HEADER: ext_hdr = val;
            CSR_IGNORE_ORDER:    skip_order = val;
            default: ;
         endcase
      endfunction

      function void add_result(logic [2:0] kind, logic [7:0] b, int unsigned off);
         psr_result_type r;
         r = '0;
         r.kind = kind;
         r.crc_error_count = crc_fail_total;
         if (kind == KIND_BYTE) begin
            r.section_byte = b;
            r.byte_offset = off[11:0];
         end else begin
            r.tbl_id = hdr[0];
            r.sect_len = hdr_length();
         end
         step_buf[step_n] = r;
         step_n++;
      endfunction

      function logic header_valid();
         logic [11:0] slen;
         logic        ssi;
         slen = hdr_length();
         ssi = hdr[1][7];
         if (hdr[0] == FILLER_BYTE) return 1'b0;
         if ((hdr[1] & RESERVED_MASK) != RESERVED_MASK) return 1'b0;
         if (int'(slen) > MAX_LENGTH_FIELD) return 1'b0;
         if (ssi != ext_hdr) return 1'b0;
         if (ssi) begin
            if ((hdr[5] & VERSION_MASK) != VERSION_MASK) return 1'b0;
            if (!skip_order && hdr[6] > hdr[7]) return 1'b0;
            if (slen < MIN_LONG_LEN) return 1'b0;
         end
         return 1'b1;
      endfunction

      function void finish_section();
         if (run_crc == '0) begin
            add_result(KIND_GOOD, '0, 0);
         end else begin
            if (crc_fail_total != COUNT_MAX) crc_fail_total++;
            add_result(KIND_CRC_ERR, '0, 0);
         end
         drop_section();
      endfunction

      // returns 0 when the header was rejected
      function logic take_section_byte(logic [7:0] b);
         int unsigned hsize;
         add_result(KIND_BYTE, b, section_fill);
         run_crc = crc_after_byte(run_crc, b);
         if (!in_body) begin
            hsize = ext_hdr ? int'(HDR_LONG) : int'(HDR_SHORT);
            hdr[section_fill[2:0]] = b;
            section_fill++;
            if (section_fill < hsize) return 1'b1;
            if (!header_valid()) begin
               add_result(KIND_REJECTED, '0, 0);
               drop_section();
               return 1'b0;
            end
            section_end = int'(HDR_SHORT) + int'(hdr_length());
            in_body = 1'b1;
            if (section_fill >= section_end) finish_section();
            return 1'b1;
         end
         section_fill++;
         if (section_fill >= section_end) finish_section();
         return 1'b1;
      endfunction

      function void absorb_payload_byte(logic [7:0] b, logic fop, logic us, logic [7:0] plen);
         logic busy;
         step_n = 0;
         requests++;
         if (fop) begin
            pkt_len = int'(plen);
            pkt_unit = us;
            pos = 0;
            pkt_phase = PHASE_CONT;
            if (pkt_len == 0) begin
               pkt_phase = PHASE_IDLE;
               return;
            end
            if (pkt_unit) begin
               pointed_pos = int'(b) + 1;
               pos = 1;
               if (pointed_pos >= pkt_len) pkt_phase = PHASE_IDLE;
               return;
            end
         end
         if (pkt_phase == PHASE_IDLE || pos >= pkt_len) begin
            pkt_phase = PHASE_IDLE;
            return;
         end
         if (pkt_phase == PHASE_CONT && pkt_unit && pos == pointed_pos) begin
            if (section_fill > 0 || in_body) begin
               add_result(KIND_ABANDON, '0, 0);
               drop_section();
            end
            pkt_phase = PHASE_NEW;
         end
         busy = in_body || section_fill > 0;
         if (pkt_phase == PHASE_CONT) begin
            if (busy) void'(take_section_byte(b));
         end else if (!busy && pos != pointed_pos && b == FILLER_BYTE) begin
            pkt_phase = PHASE_IDLE;
         end else if (!take_section_byte(b)) begin
            pkt_phase = PHASE_IDLE;
         end
         pos++;
         if (pos >= pkt_len) pkt_phase = PHASE_IDLE;
         if (step_n > 0) step_buf[step_n - 1].last = 1'b1;
         for (int i = 0; i < step_n; i++) expected_section_events.push_back(step_buf[i]);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(psr_result_type got);
         psr_result_type want;
         checked++;
         if (expected_section_events.size() == 0) begin
            $error("unexpected response: kind %0d byte 0x%0h", got.kind, got.section_byte);
            mismatches++;
            return;
         end
         want = expected_section_events.pop_front();
         kind_count[want.kind]++;
         compare_field("kind", 32'(want.kind), 32'(got.kind));
         compare_field("section_byte", 32'(want.section_byte), 32'(got.section_byte));
         compare_field("byte_offset", 32'(want.byte_offset), 32'(got.byte_offset));
         compare_field("tbl_id", 32'(want.tbl_id), 32'(got.tbl_id));
         compare_field("sect_len", 32'(want.sect_len), 32'(got.sect_len));
         compare_field("crc_error_count", want.crc_error_count, got.crc_error_count);
         compare_field("last", 32'(want.last), 32'(got.last));
      endfunction
   endclass

   psi_section_tracker_type tracker = new();

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready) begin
            tracker.write_register(csr_ch.index, csr_ch.data);
         end
         if (req_ch.valid && req_ch.ready) begin
            tracker.absorb_payload_byte(req_ch.data_byte, req_ch.first_of_packet,
                                        req_ch.unit_start, req_ch.payload_length);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            tracker.check_response({rsp_ch.kind, rsp_ch.section_byte, rsp_ch.byte_offset,
                                    rsp_ch.tbl_id, rsp_ch.sect_len,
                                    rsp_ch.crc_error_count, rsp_ch.last});
         end
      end
   end

   task automatic send_request(input logic [7:0] b, input logic fop, input logic us,
                               input logic [7:0] plen);
      if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < src_idle_pct);
      end
      req_ch.valid <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.first_of_packet <= fop;
      req_ch.unit_start <= us;
      req_ch.payload_length <= plen;
      do @(posedge clock); while (!req_ch.ready);
      sent_items++;
   endtask

   task automatic send_packet(input logic [7:0] pay [$], input logic unit,
                              input logic [7:0] plen);
      foreach (pay[i]) send_request(pay[i], i == 0, unit, plen);
   endtask

   task automatic write_registers(input logic ext, input logic skip);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= CSR_EXTENDED_HEADER;
      csr_ch.data <= ext;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.index <= CSR_IGNORE_ORDER;
      csr_ch.data <= skip;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   // drain all outstanding responses, then give the pipeline time to go quiet
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (tracker.expected_section_events.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // one section into section_q; long sections are cut short and left to be abandoned
   function automatic void build_section(logic ext);
      section_flaw_type flaw;
      int unsigned   slen;
      int unsigned   total;
      int unsigned   idx;
      logic [31:0]   c;
      logic [7:0]    last_num;
      flaw = ($urandom_range(0, 99) < 16) ? section_flaw_type'($urandom_range(1, 7))
                                          : FLAW_NONE;
      section_cut = ($urandom_range(0, 99) < 4);
      if (section_cut) slen = $urandom_range(1000, 4095);
      else if (ext) slen = $urandom_range(9, 48);
      else slen = $urandom_range(0, 40);
      if (flaw == FLAW_SHORT_LEN && ext) slen = $urandom_range(0, 8);
      section_q.delete();
      section_q.push_back(8'($urandom_range(0, 254)));
      section_q.push_back({ext, 1'($urandom_range(0, 1)), 2'b00, slen[11:8]} | RESERVED_MASK);
      section_q.push_back(slen[7:0]);
      if (ext) begin
         section_q.push_back(8'($urandom_range(0, 255)));
         section_q.push_back(8'($urandom_range(0, 255)));
         section_q.push_back(8'($urandom_range(0, 63)) | VERSION_MASK);
         last_num = 8'($urandom_range(0, 255));
         section_q.push_back(8'($urandom_range(0, last_num)));
         section_q.push_back(last_num);
      end
      case (flaw)
         FLAW_FILLER_ID: section_q[0] = FILLER_BYTE;
         FLAW_RESERVED:  section_q[1] = section_q[1] ^
                                        (RESERVED_MASK & 8'($urandom_range(1, 3) << 4));
         FLAW_SYNTAX:    section_q[1] = section_q[1] ^ 8'h80;
         FLAW_VERSION:   if (ext) section_q[5] = section_q[5] ^
                                                 (VERSION_MASK & 8'($urandom_range(1, 3) << 6));
         FLAW_ORDER:     if (ext && section_q[7] != 8'hFF) section_q[6] = section_q[7] + 8'd1;
         default: ;
      endcase
      if (section_cut) begin
         repeat ($urandom_range(0, 20)) section_q.push_back(8'($urandom_range(0, 255)));
         return;
      end
      total = int'(HDR_SHORT) + slen;
      if (slen >= 4) begin
         while (section_q.size() < total - 4) section_q.push_back(8'($urandom_range(0, 255)));
         c = CRC_INIT;
         foreach (section_q[i]) c = crc_after_byte(c, section_q[i]);
         section_q.push_back(c[31:24]);
         section_q.push_back(c[23:16]);
         section_q.push_back(c[15:8]);
         section_q.push_back(c[7:0]);
      end else begin
         while (section_q.size() < total) section_q.push_back(8'($urandom_range(0, 255)));
      end
      if (flaw == FLAW_CRC && section_q.size() > 4) begin
         idx = $urandom_range(3, section_q.size() - 1);
         section_q[idx] = section_q[idx] ^ 8'(1 << $urandom_range(0, 7));
      end
   endfunction

   task automatic send_random_packet(input logic ext);
      logic [7:0]  pay [$];
      int unsigned plen;
      int unsigned r;
      logic        unit;
      r = $urandom_range(0, 99);
      if (r < 10) plen = 184;
      else if (r < 30) plen = $urandom_range(1, 184);
      else plen = $urandom_range(4, 48);
      // broken packet: random pointer, cut short or running past its length
      if ($urandom_range(0, 99) < 8) begin
         unit = 1'($urandom_range(0, 1));
         repeat ($urandom_range(1, plen + 3)) pay.push_back(8'($urandom_range(0, 255)));
         carry_q.delete();
         restart_next = 1'b1;
         send_packet(pay, unit, 8'(plen));
         return;
      end
      unit = restart_next || carry_q.size() == 0 ||
             (carry_q.size() + 1 < plen && $urandom_range(0, 99) < 35);
      if (!unit) begin
         while (pay.size() < plen && carry_q.size() != 0) pay.push_back(carry_q.pop_front());
         while (pay.size() < plen) pay.push_back(8'($urandom_range(0, 255)));
      end else begin
         if (carry_q.size() + 1 >= plen) carry_q.delete();
         pay.push_back(8'(carry_q.size()));
         while (carry_q.size() != 0) pay.push_back(carry_q.pop_front());
         restart_next = 1'b0;
         while (pay.size() < plen) begin
            if ($urandom_range(0, 99) < 12) begin
               pay.push_back(FILLER_BYTE);
               while (pay.size() < plen) pay.push_back(8'($urandom_range(0, 255)));
            end else begin
               build_section(ext);
               foreach (section_q[i]) begin
                  if (pay.size() < plen) pay.push_back(section_q[i]);
                  else carry_q.push_back(section_q[i]);
               end
               if (section_cut) begin
                  restart_next = 1'b1;
                  while (pay.size() < plen) pay.push_back(8'($urandom_range(0, 255)));
               end
            end
         end
      end
      send_packet(pay, unit, 8'(plen));
   endtask

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("FAIL psi_section_reassembler");
      $finish;
   end

   initial begin : stimulus
      logic [7:0]  pkt_q [$];
      int unsigned start;
      logic        ext;
      logic        skip;
      req_ch.valid = 1'b0;
      req_ch.data_byte = '0;
      req_ch.first_of_packet = 1'b0;
      req_ch.unit_start = 1'b0;
      req_ch.payload_length = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_EXTENDED_HEADER;
      csr_ch.data = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: stray byte, empty packet, pointer past the payload
      send_request(8'h47, 1'b0, 1'b0, 8'd10);
      pkt_q = '{8'h00};
      send_packet(pkt_q, 1'b1, 8'd0);
      pkt_q = '{8'd5, 8'h12};
      send_packet(pkt_q, 1'b1, 8'd3);
      settle();

      write_registers(1'b0, 1'b1);
      // filler taken as table id at the pointer
      pkt_q = '{8'h00, 8'hFF, 8'h30, 8'h00};
      send_packet(pkt_q, 1'b1, 8'd4);
      // zero-length short section, then filler ends the packet
      pkt_q = '{8'h00, 8'h00, 8'h30, 8'h00, 8'hFF, 8'h11};
      send_packet(pkt_q, 1'b1, 8'd6);
      // max-length header left open, abandoned by the next unit start
      pkt_q = '{8'h00, 8'hFE, 8'h3F, 8'hFD, 8'hAA};
      send_packet(pkt_q, 1'b1, 8'd5);
      pkt_q = '{8'h00, 8'h00, 8'h70, 8'h00};
      send_packet(pkt_q, 1'b1, 8'd4);
      settle();

      for (int p = 0; p < 6; p++) begin
         case (p / 2)
            0: begin
               src_idle_pct = 31;
               snk_idle_pct = 73;
            end
            1: begin
               src_idle_pct = 73;
               snk_idle_pct = 31;
            end
            default: begin
               src_idle_pct = 0;
               snk_idle_pct = 0;
            end
         endcase
         ext = (p % 2 == 0);
         skip = (p % 3 == 2);
         write_registers(ext, skip);
         start = sent_items;
         while (sent_items - start < PHASE_REQUESTS) send_random_packet(ext);
         settle();
      end

      $display("Sent %0d payload bytes across six random phases; %0d responses checked.",
               tracker.requests, tracker.checked);
      $display("Verdicts: %0d good, %0d crc error, %0d rejected, %0d abandoned.",
               tracker.kind_count[KIND_GOOD], tracker.kind_count[KIND_CRC_ERR],
               tracker.kind_count[KIND_REJECTED], tracker.kind_count[KIND_ABANDON]);
      if (tracker.mismatches == 0 && tracker.expected_section_events.size() == 0) begin
         $display("PASS psi_section_reassembler");
      end else begin
         $display("FAIL psi_section_reassembler");
      end
      $finish;
   end

endmodule

### filelist.f
sv/psr_pkg.sv
sv/psr_if.sv
sv/psr_core.sv
sv/psr_out_stage.sv
sv/psi_section_reassembler.sv
bench/psi_section_reassembler_tb.sv
